// ----- design/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg - keyframe curve evaluator shared definitions
// Widths, codes, item/result types and a saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kce_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int FRAC_BITS = 16;

    localparam int ADDR_W = $clog2(MAX_KEYS);
    localparam int CUR_W  = $clog2(MAX_KEYS + 1);
    localparam int U_W    = FRAC_BITS + 2;        // fraction 0 .. 1.0, signed
    localparam int ACC_W  = 42;                   // Bezier accumulator
    localparam int PROD_W = ACC_W + U_W;
    localparam int NUM_W  = 40;                   // slope numerator before scaling
    localparam int DVD_W  = NUM_W + FRAC_BITS;    // divider dividend
    localparam int DVS_W  = 34;                   // divider divisor

    localparam logic [31:0]    ONE_Q32 = 32'(1) << FRAC_BITS;
    localparam logic [U_W-1:0] U_ONE   = U_W'(1) << FRAC_BITS;
    localparam longint         DERIV_LIM = 64'sd1 << 38;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_CURSOR = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    // interpolation modes (anything above linear is Bezier)
    localparam logic [1:0] IM_CONST  = 2'd0;
    localparam logic [1:0] IM_LINEAR = 2'd1;

    // result status
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_INTERP = 2'd0;
    localparam logic [1:0] REG_EXTEND = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0] interp_mode;
        logic       extend_mode;
        logic [6:0] key_count;
    } kce_cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         entry_index;
        logic signed [31:0] sample_time;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] handle_before;
        logic signed [31:0] handle_after;
    } kce_item_t;

    typedef struct packed {
        logic signed [31:0] handle_after;
        logic signed [31:0] handle_before;
        logic [2:0][31:0]   val;
        logic signed [31:0] ktime;
    } kce_key_t;

    typedef struct packed {
        logic [2:0][31:0] value;
        logic [2:0][31:0] slope;
        logic [5:0]       segment_used;
        logic [1:0]       status;
    } kce_result_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v[63:31] == '0 || v[63:31] == '1)
            r = v[31:0];
        else if (v[63])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

endpackage

// ----- design/kce_div.sv -----
// ----------------------------------------------------------------------------
// kce_div - shared signed divider
// Restoring, one quotient bit per cycle; truncates toward zero, remainder
// takes the sign of the dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kce_div
    import kce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic signed [DVS_W-1:0] divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient,
    output logic signed [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        rem_sh     = {rem_reg, quo_reg[DVD_W-1]};
        diff       = rem_sh - {1'b0, dvs_reg};
        if (busy_reg)
        begin
            if (!diff[DVS_W])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(DVD_W);
            quo_next   = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            dvs_next   = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
            rem_next   = '0;
            neg_q_next = dividend[DVD_W-1] ^ divisor[DVS_W-1];
            neg_r_next = dividend[DVD_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign remainder = neg_r_reg ? -$signed(rem_reg) : $signed(rem_reg);

endmodule

// ----- design/kce_seq.sv -----
// ----------------------------------------------------------------------------
// kce_seq - keyframe store and evaluation sequencer
// Key table, segment walk, shared multiplier and divider control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kce_seq
    import kce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  kce_cfg_t    cfg,
    input  logic        item_valid,
    input  kce_item_t   item,
    output logic        item_ready,
    output logic        res_valid,
    input  logic        res_take,
    output kce_result_t res
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SINGLE   = 5'd1;
    localparam logic [4:0] S_LD_START = 5'd2;
    localparam logic [4:0] S_LD_END   = 5'd3;
    localparam logic [4:0] S_WRAP     = 5'd4;
    localparam logic [4:0] S_CUR      = 5'd5;
    localparam logic [4:0] S_CUR_CHK  = 5'd6;
    localparam logic [4:0] S_SCAN     = 5'd7;
    localparam logic [4:0] S_LD_P0    = 5'd8;
    localparam logic [4:0] S_LD_P1    = 5'd9;
    localparam logic [4:0] S_U_DIV    = 5'd10;
    localparam logic [4:0] S_AX       = 5'd11;
    localparam logic [4:0] S_BZ_COEF  = 5'd12;
    localparam logic [4:0] S_MUL_W    = 5'd13;
    localparam logic [4:0] S_MUL_A    = 5'd14;
    localparam logic [4:0] S_SLP      = 5'd15;
    localparam logic [4:0] S_SLP_DIV  = 5'd16;
    localparam logic [4:0] S_AX_NEXT  = 5'd17;
    localparam logic [4:0] S_FIN      = 5'd18;

    // multiply steps: Bezier value 0..2, Bezier slope 3..4, linear
    localparam logic [2:0] STEP_A   = 3'd0;
    localparam logic [2:0] STEP_B   = 3'd1;
    localparam logic [2:0] STEP_C   = 3'd2;
    localparam logic [2:0] STEP_DA  = 3'd3;
    localparam logic [2:0] STEP_DB  = 3'd4;
    localparam logic [2:0] STEP_LIN = 3'd5;

    // key table
    kce_key_t          mem [MAX_KEYS];
    kce_key_t          mem_q_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    kce_key_t          wr_entry;

    // control
    logic [4:0]       state_reg, state_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;

    // datapath
    logic signed [31:0]      t_reg, t_next;
    logic signed [31:0]      first_t_reg, first_t_next;
    logic signed [32:0]      len_reg, len_next;
    logic [CUR_W-1:0]        count_reg, count_next;
    logic [CUR_W-1:0]        n_reg, n_next;
    logic [ADDR_W-1:0]       seg_reg, seg_next;
    logic signed [31:0]      t0_reg, t0_next;
    logic signed [32:0]      span_reg, span_next;
    logic [2:0][31:0]        v0_reg, v0_next;
    logic [2:0][31:0]        v1_reg, v1_next;
    logic signed [31:0]      h_after_reg, h_after_next;
    logic signed [31:0]      h_before_reg, h_before_next;
    logic signed [U_W-1:0]   u_reg, u_next;
    logic [1:0]              axis_reg, axis_next;
    logic [2:0]              step_reg, step_next;
    logic signed [ACC_W-1:0] a_reg, a_next;
    logic signed [ACC_W-1:0] b_reg, b_next;
    logic signed [ACC_W-1:0] c_reg, c_next;
    logic signed [ACC_W-1:0] mul_op_reg, mul_op_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [2:0][31:0]        val_reg, val_next;
    logic [2:0][31:0]        slp_reg, slp_next;
    logic [1:0]              status_reg, status_next;

    // divider
    logic                    div_start;
    logic signed [DVD_W-1:0] div_dvd;
    logic signed [DVS_W-1:0] div_dvs;
    logic                    div_done;
    logic signed [DVD_W-1:0] div_quo;
    logic signed [DVS_W-1:0] div_rem;

    // scratch
    logic [CUR_W-1:0]   count_eff;
    logic [CUR_W-1:0]   n_w;
    logic signed [32:0] diff33;
    logic signed [32:0] dt33;
    logic signed [DVS_W-1:0] r_w;
    logic signed [DVS_W-1:0] tw;
    logic signed [63:0] p0_w, p1_w, p2_w, p3_w;
    logic signed [63:0] c_w, b_w, a_w;
    logic signed [63:0] sh_w, sum_w;

    kce_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign count_eff = (cfg.key_count > 7'(MAX_KEYS)) ? CUR_W'(MAX_KEYS)
                                                       : CUR_W'(cfg.key_count);

    assign wr_en = item_valid && (state_reg == S_IDLE) && (item.opcode == OP_WRITE)
                   && (32'(item.entry_index) < 32'(MAX_KEYS));
    assign wr_entry = '{handle_after:  item.handle_after,
                        handle_before: item.handle_before,
                        val:           {item.in_z, item.in_y, item.in_x},
                        ktime:         item.sample_time};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ADDR_W'(item.entry_index)] <= wr_entry;
        mem_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        t_next        = t_reg;
        first_t_next  = first_t_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        seg_next      = seg_reg;
        t0_next       = t0_reg;
        span_next     = span_reg;
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        h_after_next  = h_after_reg;
        h_before_next = h_before_reg;
        u_next        = u_reg;
        axis_next     = axis_reg;
        step_next     = step_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        mul_op_next   = mul_op_reg;
        num_next      = num_reg;
        val_next      = val_reg;
        slp_next      = slp_reg;
        status_next   = status_reg;
        rd_addr       = '0;
        div_start     = 1'b0;
        div_dvd       = '0;
        div_dvs       = '0;
        item_ready    = 1'b0;
        res_valid     = 1'b0;
        n_w           = n_reg;
        diff33        = '0;
        dt33          = '0;
        r_w           = '0;
        tw            = '0;
        p0_w          = 64'($signed(v0_reg[axis_reg]));
        p3_w          = 64'($signed(v1_reg[axis_reg]));
        p1_w          = (axis_reg == 2'd0) ? 64'(h_after_reg) : 64'sd0;
        p2_w          = (axis_reg == 2'd0) ? 64'(h_before_reg) : 64'sd0;
        c_w           = '0;
        b_w           = '0;
        a_w           = '0;
        sh_w          = 64'(prod_reg >>> FRAC_BITS);
        sum_w         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item.opcode == OP_CURSOR)
                        cursor_next = CUR_W'(1);
                    else if (item.opcode == OP_EVAL)
                    begin
                        t_next      = item.sample_time;
                        count_next  = count_eff;
                        status_next = ST_NORMAL;
                        val_next    = '0;
                        slp_next    = '0;
                        seg_next    = '0;
                        if (count_eff == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else if (count_eff == CUR_W'(1))
                            state_next = S_SINGLE;
                        else
                            state_next = S_LD_START;
                    end
                end
            end

            S_SINGLE:
            begin
                val_next    = mem_q_reg.val;
                slp_next[0] = ONE_Q32;
                status_next = ST_SINGLE;
                state_next  = S_FIN;
            end

            S_LD_START:
            begin
                first_t_next = mem_q_reg.ktime;
                rd_addr      = ADDR_W'(count_reg - 1'b1);
                state_next   = S_LD_END;
            end

            S_LD_END:
            begin
                state_next = S_CUR;
                if (t_reg < first_t_reg || t_reg > mem_q_reg.ktime)
                begin
                    if (cfg.extend_mode)
                    begin
                        diff33   = 33'(mem_q_reg.ktime) - 33'(first_t_reg);
                        len_next = diff33;
                        if (diff33[32] || diff33 == '0)
                            t_next = first_t_reg;
                        else
                        begin
                            dt33       = 33'(t_reg) - 33'(first_t_reg);
                            div_start  = 1'b1;
                            div_dvd    = DVD_W'(dt33);
                            div_dvs    = DVS_W'(diff33);
                            state_next = S_WRAP;
                        end
                    end
                    else
                        t_next = (t_reg < first_t_reg) ? first_t_reg : mem_q_reg.ktime;
                end
            end

            S_WRAP:
            begin
                if (div_done)
                begin
                    r_w        = div_rem[DVS_W-1] ? div_rem + DVS_W'(len_reg) : div_rem;
                    tw         = DVS_W'(first_t_reg) + r_w;
                    t_next     = tw[31:0];
                    state_next = S_CUR;
                end
            end

            S_CUR:
            begin
                n_w = cursor_reg;
                if (n_w == '0 || n_w > count_reg - 1'b1)
                    n_w = CUR_W'(1);
                n_next     = n_w;
                rd_addr    = ADDR_W'(n_w - 1'b1);
                state_next = S_CUR_CHK;
            end

            S_CUR_CHK:
            begin
                n_w = n_reg;
                if (t_reg < mem_q_reg.ktime)
                    n_w = CUR_W'(1);
                n_next     = n_w;
                rd_addr    = ADDR_W'(n_w);
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (n_reg < count_reg - 1'b1 && t_reg >= mem_q_reg.ktime)
                begin
                    n_next  = n_reg + 1'b1;
                    rd_addr = ADDR_W'(n_reg + 1'b1);
                end
                else
                begin
                    cursor_next = n_reg;
                    seg_next    = ADDR_W'(n_reg - 1'b1);
                    rd_addr     = ADDR_W'(n_reg - 1'b1);
                    state_next  = S_LD_P0;
                end
            end

            S_LD_P0:
            begin
                t0_next      = mem_q_reg.ktime;
                v0_next      = mem_q_reg.val;
                h_after_next = mem_q_reg.handle_after;
                rd_addr      = seg_reg + 1'b1;
                state_next   = S_LD_P1;
            end

            S_LD_P1:
            begin
                v1_next       = mem_q_reg.val;
                h_before_next = mem_q_reg.handle_before;
                diff33        = 33'(mem_q_reg.ktime) - 33'(t0_reg);
                dt33          = 33'(t_reg) - 33'(t0_reg);
                span_next     = diff33;
                axis_next     = '0;
                if (diff33[32] || diff33 == '0)
                begin
                    u_next     = U_ONE;
                    state_next = S_AX;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(dt33) <<< FRAC_BITS;
                    div_dvs    = DVS_W'(diff33);
                    state_next = S_U_DIV;
                end
            end

            S_U_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo[DVD_W-1])
                        u_next = '0;
                    else if (div_quo > DVD_W'(U_ONE))
                        u_next = U_ONE;
                    else
                        u_next = U_W'(div_quo);
                    state_next = S_AX;
                end
            end

            S_AX:
            begin
                if (cfg.interp_mode == IM_CONST)
                begin
                    val_next[axis_reg] = v0_reg[axis_reg];
                    slp_next[axis_reg] = '0;
                    state_next         = S_AX_NEXT;
                end
                else if (cfg.interp_mode == IM_LINEAR)
                begin
                    sum_w       = p3_w - p0_w;
                    mul_op_next = ACC_W'(sum_w);
                    num_next    = NUM_W'(sum_w);
                    step_next   = STEP_LIN;
                    state_next  = S_MUL_W;
                end
                else
                begin
                    c_w        = 3 * (p1_w - p0_w);
                    b_w        = 3 * (p2_w - p1_w) - c_w;
                    c_next     = ACC_W'(c_w);
                    b_next     = ACC_W'(b_w);
                    state_next = S_BZ_COEF;
                end
            end

            S_BZ_COEF:
            begin
                a_w         = p3_w - p0_w - 64'(c_reg) - 64'(b_reg);
                a_next      = ACC_W'(a_w);
                mul_op_next = ACC_W'(a_w);
                step_next   = STEP_A;
                state_next  = S_MUL_W;
            end

            S_MUL_W:
                state_next = S_MUL_A;

            S_MUL_A:
            begin
                state_next = S_MUL_W;
                unique case (step_reg)
                    STEP_A:
                    begin
                        mul_op_next = ACC_W'(sh_w + 64'(b_reg));
                        step_next   = STEP_B;
                    end
                    STEP_B:
                    begin
                        mul_op_next = ACC_W'(sh_w + 64'(c_reg));
                        step_next   = STEP_C;
                    end
                    STEP_C:
                    begin
                        val_next[axis_reg] = sat32(sh_w + p0_w);
                        mul_op_next        = ACC_W'(3 * 64'(a_reg));
                        step_next          = STEP_DA;
                    end
                    STEP_DA:
                    begin
                        mul_op_next = ACC_W'(sh_w + 2 * 64'(b_reg));
                        step_next   = STEP_DB;
                    end
                    STEP_DB:
                    begin
                        sum_w = sh_w + 64'(c_reg);
                        if (sum_w > DERIV_LIM)
                            sum_w = DERIV_LIM;
                        else if (sum_w < -DERIV_LIM)
                            sum_w = -DERIV_LIM;
                        num_next   = NUM_W'(sum_w);
                        state_next = S_SLP;
                    end
                    STEP_LIN:
                    begin
                        val_next[axis_reg] = sat32(p0_w + sh_w);
                        state_next         = S_SLP;
                    end
                    default:
                        state_next = S_SLP;
                endcase
            end

            S_SLP:
            begin
                if (span_reg == '0)
                begin
                    if (num_reg > 0)
                        slp_next[axis_reg] = 32'h7FFF_FFFF;
                    else if (num_reg < 0)
                        slp_next[axis_reg] = 32'h8000_0000;
                    else
                        slp_next[axis_reg] = '0;
                    state_next = S_AX_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(num_reg) <<< FRAC_BITS;
                    div_dvs    = DVS_W'(span_reg);
                    state_next = S_SLP_DIV;
                end
            end

            S_SLP_DIV:
            begin
                if (div_done)
                begin
                    slp_next[axis_reg] = sat32(64'(div_quo));
                    state_next         = S_AX_NEXT;
                end
            end

            S_AX_NEXT:
            begin
                if (axis_reg == 2'd2)
                    state_next = S_FIN;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_AX;
                end
            end

            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= CUR_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        first_t_reg  <= first_t_next;
        len_reg      <= len_next;
        count_reg    <= count_next;
        n_reg        <= n_next;
        seg_reg      <= seg_next;
        t0_reg       <= t0_next;
        span_reg     <= span_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        h_after_reg  <= h_after_next;
        h_before_reg <= h_before_next;
        u_reg        <= u_next;
        axis_reg     <= axis_next;
        step_reg     <= step_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        mul_op_reg   <= mul_op_next;
        prod_reg     <= PROD_W'(mul_op_reg) * PROD_W'(u_reg);
        num_reg      <= num_next;
        val_reg      <= val_next;
        slp_reg      <= slp_next;
        status_reg   <= status_next;
    end

    assign res.value        = val_reg;
    assign res.slope        = slp_reg;
    assign res.segment_used = 6'(seg_reg);
    assign res.status       = status_reg;

endmodule

// ----- design/keyframe_curve_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator_core - keyframe curve evaluator, top level
// Keyframe table with constant, linear and cubic Bezier evaluation in Q16.16.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               content
//  s_axis    in         s_axis_tvalid/tready    write / cursor reset / evaluate
//  m_axis    out        m_axis_tvalid/tready    values, slopes, segment, status
//  cfg       in         cfg_valid/cfg_ready     interp, extend, key count
//
//  Write and cursor-reset items complete on acceptance. An evaluate runs
//  through one sequencer: sequencing and table reads, the segment walk over
//  the keys, the multiplies and the divisions on the single shared divider
//  (fraction, optional wrap, one slope per axis); the divider dominates.
//  Reset is asynchronous and active low; the cursor returns to one. The key
//  table is not cleared. A result sits in the output register until taken,
//  so the next item can enter while it waits; a second finished result
//  waits inside the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyframe_curve_evaluator_core
    import kce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // entry_index[5:0], sample_time[37:6], in_x[69:38], in_y[101:70],
    // in_z[133:102], handle_before[165:134], handle_after[197:166], zero pad
    input  logic [199:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,    // opcode[1:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // value_x[31:0], value_y[63:32], value_z[95:64], slope_x[127:96],
    // slope_y[159:128], slope_z[191:160], segment_used[197:192], zero pad
    output logic [199:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,    // status[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    kce_cfg_t    cfg_reg, cfg_next;
    kce_item_t   item;
    logic        item_ready;
    logic        res_valid;
    logic        res_take;
    kce_result_t res;
    logic        out_valid_reg, out_valid_next;
    kce_result_t out_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INTERP: cfg_next.interp_mode = cfg_data[1:0];
                REG_EXTEND: cfg_next.extend_mode = cfg_data[0];
                REG_COUNT:  cfg_next.key_count   = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // unpack the input item
    assign item.opcode        = s_axis_tuser;
    assign item.entry_index   = s_axis_tdata[5:0];
    assign item.sample_time   = s_axis_tdata[37:6];
    assign item.in_x          = s_axis_tdata[69:38];
    assign item.in_y          = s_axis_tdata[101:70];
    assign item.in_z          = s_axis_tdata[133:102];
    assign item.handle_before = s_axis_tdata[165:134];
    assign item.handle_after  = s_axis_tdata[197:166];

    assign s_axis_tready = item_ready;

    kce_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (s_axis_tvalid),
        .item       (item),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // output register: load when empty or being drained
    assign res_take = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{interp_mode: IM_LINEAR, extend_mode: 1'b0, key_count: 7'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {2'b00, out_reg.segment_used, out_reg.slope, out_reg.value};

endmodule

// ----- design/kce_checker.sv -----
// ----------------------------------------------------------------------------
// kce_checker - port-level checks for the keyframe curve evaluator
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kce_checker
    import kce_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic [199:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // empty table gives an all-zero result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata == '0)
        else $error("empty-table result not zero");

    // single key: segment 0, unit x slope, zero y/z slope
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_SINGLE |->
            m_axis_tdata[197:192] == 6'd0 && m_axis_tdata[127:96] == ONE_Q32
            && m_axis_tdata[191:128] == '0)
        else $error("single-key result malformed");

    // no unused status code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser == ST_NORMAL || m_axis_tuser == ST_SINGLE
                          || m_axis_tuser == ST_EMPTY)
        else $error("bad status code");

endmodule

bind keyframe_curve_evaluator_core kce_checker u_kce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
